// ----- rtl/frpm_pkg.sv -----
// ----------------------------------------------------------------------------
// frpm_pkg
// Shared constants, step codes and controller/datapath interface types for
// the flash record page manager.
// ----------------------------------------------------------------------------
package frpm_pkg;

    localparam int PAGE_COUNT       = 8;
    localparam int PAGE_W           = $clog2(PAGE_COUNT);
    localparam int PAGE_BYTES       = 2048;
    localparam int PAGE_SHIFT       = $clog2(PAGE_BYTES);
    localparam int MAX_RECORD_BYTES = 256;
    localparam int FULL_COUNT       = 33;
    localparam int MAX_INV_WRITES   = 7;

    // opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOCATE = 2'd1;
    localparam logic [1:0] OP_INVAL  = 2'd2;

    // page status
    localparam logic [1:0] PS_GOOD  = 2'd0;
    localparam logic [1:0] PS_STALE = 2'd1;
    localparam logic [1:0] PS_CLEAN = 2'd2;

    // actions
    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_WDATA = 3'd2;
    localparam logic [2:0] ACT_RDATA = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    // result status
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_REJECT = 2'd1;
    localparam logic [1:0] STS_FAIL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [1:0] CFG_INVALID_TAG = 2'd1;

    // controller steps
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;
    localparam logic [3:0] S_FIT    = 4'd2;
    localparam logic [3:0] S_BUMP   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_ERASE  = 4'd5;
    localparam logic [3:0] S_FAIL   = 4'd6;
    localparam logic [3:0] S_RECENT = 4'd7;
    localparam logic [3:0] S_NEWHDR = 4'd8;
    localparam logic [3:0] S_OLDHDR = 4'd9;
    localparam logic [3:0] S_DATA   = 4'd10;
    localparam logic [3:0] S_READ   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;
    localparam logic [3:0] S_REJECT = 4'd13;
    localparam logic [3:0] S_INV    = 4'd14;
    localparam logic [3:0] S_INVEND = 4'd15;

    typedef struct packed {
        logic [3:0] step;
        logic       fire;
    } frpm_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       bad;
        logic       old_hit;
        logic       fit;
        logic       full;
        logic       have_clean;
        logic       have_stale;
        logic       eok;
        logic       inv_emit;
        logic       inv_last;
        logic       out_free;
    } frpm_status_t;

    // header word as written to flash: MRP bit 31, MRU bit 30, tag 23..0
    function automatic logic [31:0] header_word(input logic [25:0] h);
        header_word = {h[25], h[24], 6'b0, h[23:0]};
    endfunction

    // unary block counter word
    function automatic logic [31:0] unary_word(input logic [5:0] v);
        logic [31:0] w;
        w = 32'hFFFF_FFFF;
        if (v >= 6'(FULL_COUNT)) begin
            w = 32'h0000_0000;
        end else if (v > 6'd1) begin
            w = ~((32'd1 << (v - 6'd1)) - 32'd1);
        end
        unary_word = w;
    endfunction

endpackage

// ----- rtl/frpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// frpm_ctrl
// Request sequencer: walks one request through its steps and tells the
// datapath when a step completes.
// ----------------------------------------------------------------------------
module frpm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  frpm_pkg::frpm_status_t sts,
    output frpm_pkg::frpm_cmd_t    cmd
);

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       emits;
    logic       fire;

    always_comb begin
        unique case (state_reg)
            frpm_pkg::S_IDLE, frpm_pkg::S_FIND, frpm_pkg::S_FIT,
            frpm_pkg::S_SCAN: emits = 1'b0;
            frpm_pkg::S_INV:  emits = sts.inv_emit;
            default:          emits = 1'b1;
        endcase
    end

    assign fire = (state_reg == frpm_pkg::S_IDLE) ? s_valid : (!emits || sts.out_free);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            frpm_pkg::S_IDLE: state_next = frpm_pkg::S_FIND;
            frpm_pkg::S_FIND: begin
                if (sts.op == frpm_pkg::OP_INVAL) begin
                    state_next = frpm_pkg::S_INV;
                end else if (sts.op == frpm_pkg::OP_UPDATE) begin
                    state_next = sts.bad ? frpm_pkg::S_REJECT : frpm_pkg::S_FIT;
                end else if (sts.op == frpm_pkg::OP_LOCATE) begin
                    state_next = (sts.bad || !sts.old_hit) ? frpm_pkg::S_REJECT
                                                           : frpm_pkg::S_READ;
                end else begin
                    state_next = frpm_pkg::S_REJECT;
                end
            end
            frpm_pkg::S_FIT: begin
                if (sts.fit) begin
                    state_next = sts.full ? frpm_pkg::S_DATA : frpm_pkg::S_BUMP;
                end else begin
                    state_next = frpm_pkg::S_SCAN;
                end
            end
            frpm_pkg::S_BUMP: state_next = frpm_pkg::S_DATA;
            frpm_pkg::S_SCAN: begin
                if (sts.have_clean) begin
                    state_next = frpm_pkg::S_NEWHDR;
                end else if (sts.have_stale) begin
                    state_next = frpm_pkg::S_ERASE;
                end else begin
                    state_next = frpm_pkg::S_FAIL;
                end
            end
            frpm_pkg::S_ERASE:  state_next = sts.eok ? frpm_pkg::S_RECENT : frpm_pkg::S_FAIL;
            frpm_pkg::S_RECENT: state_next = frpm_pkg::S_NEWHDR;
            frpm_pkg::S_NEWHDR: state_next = sts.old_hit ? frpm_pkg::S_OLDHDR : frpm_pkg::S_DATA;
            frpm_pkg::S_OLDHDR: state_next = frpm_pkg::S_DATA;
            frpm_pkg::S_DATA:   state_next = frpm_pkg::S_DONE;
            frpm_pkg::S_READ:   state_next = frpm_pkg::S_DONE;
            frpm_pkg::S_INV:    state_next = sts.inv_last ? frpm_pkg::S_INVEND : frpm_pkg::S_INV;
            frpm_pkg::S_DONE, frpm_pkg::S_REJECT, frpm_pkg::S_FAIL,
            frpm_pkg::S_INVEND: state_next = frpm_pkg::S_IDLE;
            default:            state_next = frpm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frpm_pkg::S_IDLE;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign s_ready   = (state_reg == frpm_pkg::S_IDLE);
    assign cmd.step  = state_reg;
    assign cmd.fire  = fire;

    a_emit_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emits) |-> sts.out_free)
        else $error("result issued with output register occupied");

    a_accept_to_find: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == frpm_pkg::S_FIND))
        else $error("accepted request did not start lookup");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (state_reg == frpm_pkg::S_DONE || state_reg == frpm_pkg::S_REJECT ||
                  state_reg == frpm_pkg::S_FAIL || state_reg == frpm_pkg::S_INVEND))
        |=> s_ready)
        else $error("final word issued without returning to idle");

endmodule

// ----- rtl/frpm_datapath.sv -----
// ----------------------------------------------------------------------------
// frpm_datapath
// Page table, configuration registers, address arithmetic and the result
// output register.
// ----------------------------------------------------------------------------
module frpm_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic [1:0]             s_opcode,
    input  logic [23:0]            s_record_tag,
    input  logic [8:0]             s_record_size,
    input  logic                   s_erase_ok,
    input  frpm_pkg::frpm_cmd_t    cmd,
    output frpm_pkg::frpm_status_t sts,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_action,
    output logic [31:0]            m_flash_address,
    output logic [31:0]            m_flash_word,
    output logic [8:0]             m_data_length,
    output logic [1:0]             m_status,
    output logic                   m_last
);

    localparam int PW = frpm_pkg::PAGE_W;

    logic [31:0] region_base_reg;
    logic [23:0] invalid_tag_reg;

    logic [1:0]  page_status_reg [frpm_pkg::PAGE_COUNT];
    logic [25:0] page_header_reg [frpm_pkg::PAGE_COUNT];
    logic [31:0] block_start_reg [frpm_pkg::PAGE_COUNT];
    logic [5:0]  block_fill_reg  [frpm_pkg::PAGE_COUNT];
    logic [PW-1:0] recent_reg;

    // request
    logic [1:0]  op_reg;
    logic [23:0] tag_reg;
    logic [8:0]  size_reg;
    logic        eok_reg;

    logic [PW-1:0] old_reg;
    logic          old_hit_reg;
    logic [15:0]   prod_reg;
    logic [31:0]   dst_reg;
    logic          fit_reg;
    logic [PW-1:0] np_reg;
    logic          clean_reg;
    logic          stale_reg;
    logic [PW-1:0] inv_idx_reg;
    logic [2:0]    inv_cnt_reg;
    logic          inv_hit_reg;

    logic          m_valid_reg;
    logic [2:0]    act_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   word_reg;
    logic [8:0]    len_reg;
    logic [1:0]    stat_reg;
    logic          last_reg;

    logic [9:0]    stride;
    logic          bad;
    logic [PW-1:0] find_idx;
    logic          find_hit;
    logic [5:0]    fill_f;
    logic [5:0]    mul_a;
    logic [5:0]    fill_o;
    logic          full;
    logic [31:0]   dst_c;
    logic [31:0]   end_c;
    logic          fit_c;
    logic [PW-1:0] sc_clean;
    logic [PW-1:0] sc_stale;
    logic          sc_has_clean;
    logic          sc_has_stale;
    logic          inv_match;
    logic          inv_emit;
    logic          out_free;
    logic          do_emit;
    logic [2:0]    e_act;
    logic [31:0]   e_addr;
    logic [31:0]   e_word;
    logic [8:0]    e_len;
    logic [1:0]    e_stat;
    logic          e_last;
    logic [25:0]   recent_hdr;
    logic [25:0]   old_hdr;
    logic [25:0]   inv_hdr;

    function automatic logic [31:0] page_addr(input logic [31:0] base, input logic [PW:0] p);
        page_addr = base + (32'(p) << frpm_pkg::PAGE_SHIFT);
    endfunction

    assign stride = (10'(size_reg) + 10'd3) & ~10'd3;
    assign bad    = (tag_reg == invalid_tag_reg) ||
                    (size_reg > 9'(frpm_pkg::MAX_RECORD_BYTES));

    always_comb begin
        find_idx = '0;
        find_hit = 1'b0;
        for (int i = frpm_pkg::PAGE_COUNT - 1; i >= 0; i--) begin
            if (page_status_reg[i] == frpm_pkg::PS_GOOD &&
                page_header_reg[i][23:0] == tag_reg) begin
                find_idx = PW'(i);
                find_hit = 1'b1;
            end
        end
    end

    assign fill_f = block_fill_reg[find_idx];
    assign mul_a  = (op_reg == frpm_pkg::OP_LOCATE) ?
                    ((fill_f == 6'd0) ? 6'd0 : fill_f - 6'd1) : fill_f;

    assign fill_o = block_fill_reg[old_reg];
    assign full   = (fill_o >= 6'(frpm_pkg::FULL_COUNT));
    assign dst_c  = block_start_reg[old_reg] + 32'(prod_reg) + (full ? 32'd8 : 32'd4);
    assign end_c  = page_addr(region_base_reg, {1'b0, old_reg} + (PW+1)'(1));
    assign fit_c  = old_hit_reg && ((dst_c + 32'(stride)) <= end_c);

    // round-robin search after the most recent page
    always_comb begin
        logic [PW-1:0] p;
        sc_clean     = '0;
        sc_stale     = '0;
        sc_has_clean = 1'b0;
        sc_has_stale = 1'b0;
        for (int i = 0; i < frpm_pkg::PAGE_COUNT; i++) begin
            p = recent_reg + PW'(1) + PW'(i);
            if (!sc_has_clean) begin
                if (page_status_reg[p] == frpm_pkg::PS_CLEAN) begin
                    sc_clean     = p;
                    sc_has_clean = 1'b1;
                end else if (!sc_has_stale && page_status_reg[p] == frpm_pkg::PS_STALE) begin
                    sc_stale     = p;
                    sc_has_stale = 1'b1;
                end
            end
        end
    end

    assign inv_match = page_header_reg[inv_idx_reg][25] &&
                       (page_header_reg[inv_idx_reg][23:0] == tag_reg);
    assign inv_emit  = inv_match && (inv_cnt_reg < 3'(frpm_pkg::MAX_INV_WRITES));

    assign recent_hdr = page_header_reg[recent_reg] & ~26'h100_0000;
    assign old_hdr    = page_header_reg[old_reg] & ~26'h200_0000;
    assign inv_hdr    = page_header_reg[inv_idx_reg] & ~26'h200_0000;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        do_emit = 1'b1;
        e_act   = frpm_pkg::ACT_WRITE;
        e_addr  = '0;
        e_word  = '0;
        e_len   = '0;
        e_stat  = frpm_pkg::STS_OK;
        e_last  = 1'b0;
        unique case (cmd.step)
            frpm_pkg::S_BUMP: begin
                e_addr = block_start_reg[old_reg];
                e_word = frpm_pkg::unary_word(fill_o + 6'd1);
            end
            frpm_pkg::S_ERASE: begin
                e_act  = frpm_pkg::ACT_ERASE;
                e_addr = page_addr(region_base_reg, {1'b0, np_reg});
            end
            frpm_pkg::S_RECENT: begin
                e_addr = page_addr(region_base_reg, {1'b0, recent_reg});
                e_word = frpm_pkg::header_word(recent_hdr);
            end
            frpm_pkg::S_NEWHDR: begin
                e_addr = page_addr(region_base_reg, {1'b0, np_reg});
                e_word = frpm_pkg::header_word({2'b11, tag_reg});
            end
            frpm_pkg::S_OLDHDR: begin
                e_addr = page_addr(region_base_reg, {1'b0, old_reg});
                e_word = frpm_pkg::header_word(old_hdr);
            end
            frpm_pkg::S_INV: begin
                do_emit = inv_emit;
                e_addr  = page_addr(region_base_reg, {1'b0, inv_idx_reg});
                e_word  = frpm_pkg::header_word(inv_hdr);
            end
            frpm_pkg::S_DATA: begin
                e_act  = frpm_pkg::ACT_WDATA;
                e_addr = dst_reg;
                e_len  = size_reg;
            end
            frpm_pkg::S_READ: begin
                e_act  = frpm_pkg::ACT_RDATA;
                e_addr = block_start_reg[old_reg] + 32'd4 + 32'(prod_reg);
                e_len  = size_reg;
            end
            frpm_pkg::S_DONE: begin
                e_act  = frpm_pkg::ACT_NONE;
                e_last = 1'b1;
            end
            frpm_pkg::S_REJECT: begin
                e_act  = frpm_pkg::ACT_NONE;
                e_stat = frpm_pkg::STS_REJECT;
                e_last = 1'b1;
            end
            frpm_pkg::S_FAIL: begin
                e_act  = frpm_pkg::ACT_NONE;
                e_stat = frpm_pkg::STS_FAIL;
                e_last = 1'b1;
            end
            frpm_pkg::S_INVEND: begin
                e_act  = frpm_pkg::ACT_NONE;
                e_stat = inv_hit_reg ? frpm_pkg::STS_OK : frpm_pkg::STS_REJECT;
                e_last = 1'b1;
            end
            default: do_emit = 1'b0;
        endcase
    end

    // config and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
            invalid_tag_reg <= 24'hFF_FFFF;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    frpm_pkg::CFG_REGION_BASE: region_base_reg <= cfg_data;
                    frpm_pkg::CFG_INVALID_TAG: invalid_tag_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (cmd.fire && do_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fire && do_emit) begin
            act_reg  <= e_act;
            addr_reg <= e_addr;
            word_reg <= e_word;
            len_reg  <= e_len;
            stat_reg <= e_stat;
            last_reg <= e_last;
        end
    end

    // request working registers
    always_ff @(posedge aclk) begin
        if (cmd.fire) begin
            unique case (cmd.step)
                frpm_pkg::S_IDLE: begin
                    op_reg   <= s_opcode;
                    tag_reg  <= s_record_tag;
                    size_reg <= s_record_size;
                    eok_reg  <= s_erase_ok;
                end
                frpm_pkg::S_FIND: begin
                    old_reg     <= find_idx;
                    old_hit_reg <= find_hit;
                    prod_reg    <= 16'(mul_a) * 16'(stride);
                    inv_idx_reg <= '0;
                    inv_cnt_reg <= '0;
                    inv_hit_reg <= 1'b0;
                end
                frpm_pkg::S_FIT: begin
                    dst_reg <= dst_c;
                    fit_reg <= fit_c;
                end
                frpm_pkg::S_SCAN: begin
                    np_reg    <= sc_has_clean ? sc_clean : sc_stale;
                    clean_reg <= sc_has_clean;
                    stale_reg <= sc_has_stale;
                end
                frpm_pkg::S_NEWHDR: begin
                    dst_reg <= page_addr(region_base_reg, {1'b0, np_reg}) + 32'd8;
                end
                frpm_pkg::S_INV: begin
                    inv_idx_reg <= inv_idx_reg + PW'(1);
                    if (inv_match) begin
                        inv_hit_reg <= 1'b1;
                    end
                    if (inv_emit) begin
                        inv_cnt_reg <= inv_cnt_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // page table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < frpm_pkg::PAGE_COUNT; i++) begin
                page_status_reg[i] <= frpm_pkg::PS_CLEAN;
                page_header_reg[i] <= '0;
            end
            recent_reg <= PW'(frpm_pkg::PAGE_COUNT - 1);
        end else if (cmd.fire) begin
            unique case (cmd.step)
                frpm_pkg::S_FIT: begin
                    if (fit_c && full) begin
                        block_start_reg[old_reg] <= dst_c - 32'd4;
                        block_fill_reg[old_reg]  <= 6'd1;
                    end
                end
                frpm_pkg::S_BUMP: block_fill_reg[old_reg] <= fill_o + 6'd1;
                frpm_pkg::S_RECENT: begin
                    page_header_reg[recent_reg] <= recent_hdr;
                    recent_reg                  <= np_reg;
                end
                frpm_pkg::S_NEWHDR: begin
                    page_header_reg[np_reg] <= {2'b11, tag_reg};
                    page_status_reg[np_reg] <= frpm_pkg::PS_GOOD;
                    block_start_reg[np_reg] <= page_addr(region_base_reg, {1'b0, np_reg})
                                               + 32'd4;
                    block_fill_reg[np_reg]  <= 6'd1;
                end
                frpm_pkg::S_OLDHDR: begin
                    page_header_reg[old_reg] <= old_hdr;
                    page_status_reg[old_reg] <= frpm_pkg::PS_STALE;
                end
                frpm_pkg::S_INV: begin
                    if (inv_match) begin
                        page_header_reg[inv_idx_reg] <= inv_hdr;
                        page_status_reg[inv_idx_reg] <= frpm_pkg::PS_STALE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign sts.op         = op_reg;
    assign sts.bad        = bad;
    assign sts.old_hit    = (cmd.step == frpm_pkg::S_FIND) ? find_hit : old_hit_reg;
    assign sts.fit        = fit_c;
    assign sts.full       = full;
    assign sts.have_clean = sc_has_clean;
    assign sts.have_stale = sc_has_stale;
    assign sts.eok        = eok_reg;
    assign sts.inv_emit   = inv_emit;
    assign sts.inv_last   = (inv_idx_reg == PW'(frpm_pkg::PAGE_COUNT - 1));
    assign sts.out_free   = out_free;

    // allocation decision of the current request
    a_np_choice: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fire && cmd.step == frpm_pkg::S_NEWHDR && !fit_reg)
        |-> (clean_reg || stale_reg))
        else $error("new page opened with no clean or stale page found");

    assign m_valid         = m_valid_reg;
    assign m_action        = act_reg;
    assign m_flash_address = addr_reg;
    assign m_flash_word    = word_reg;
    assign m_data_length   = len_reg;
    assign m_status        = stat_reg;
    assign m_last          = last_reg;

endmodule

// ----- rtl/flash_record_page_manager.sv -----
// ----------------------------------------------------------------------------
// flash_record_page_manager
// Page table manager of a log-structured flash record store: turns update,
// locate and invalidate requests into flash command words and a status.
//
//  channel | ports                       | direction
//  --------+-----------------------------+----------
//  request | s_valid/s_ready, s_*        | in
//  result  | m_valid/m_ready, m_*        | out
//  config  | cfg_valid/cfg_ready, cfg_*  | in
//
// One request at a time, one sequencer step per cycle unless a stalled result
// holds it; an invalidate walks the 8 pages one per cycle on the same terms.
// Each result word leaves in its own step. A stalled result holds the
// sequencer; the next request is taken when the sequencer returns to idle.
// Reset is synchronous; all pages come up clean.
// ----------------------------------------------------------------------------
module flash_record_page_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [23:0] s_record_tag,
    input  logic [8:0]  s_record_size,
    input  logic        s_erase_ok,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [31:0] m_flash_address,
    output logic [31:0] m_flash_word,
    output logic [8:0]  m_data_length,
    output logic [1:0]  m_status,
    output logic        m_last
);

    frpm_pkg::frpm_cmd_t    cmd;
    frpm_pkg::frpm_status_t sts;

    assign cfg_ready = 1'b1;

    frpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    frpm_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_opcode        (s_opcode),
        .s_record_tag    (s_record_tag),
        .s_record_size   (s_record_size),
        .s_erase_ok      (s_erase_ok),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_flash_address (m_flash_address),
        .m_flash_word    (m_flash_word),
        .m_data_length   (m_data_length),
        .m_status        (m_status),
        .m_last          (m_last)
    );

endmodule
